>>> rtl/bre_pkg.sv
// Shared types and constants for the bytebeat postfix evaluator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package bre_pkg;

  localparam int unsigned LIT_W   = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOK_W   = 37;
  localparam int unsigned LEN_W   = 6;
  localparam logic [30:0] TIME_RESET = 31'd40761023;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Token kinds.
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;
  localparam logic [1:0] KIND_NOT  = 2'd3;

  // Binary operator codes.
  localparam logic [3:0] OPC_SHL = 4'd0;
  localparam logic [3:0] OPC_SHR = 4'd1;
  localparam logic [3:0] OPC_XOR = 4'd2;
  localparam logic [3:0] OPC_OR  = 4'd3;
  localparam logic [3:0] OPC_AND = 4'd4;
  localparam logic [3:0] OPC_ADD = 4'd5;
  localparam logic [3:0] OPC_SUB = 4'd6;
  localparam logic [3:0] OPC_MUL = 4'd7;
  localparam logic [3:0] OPC_DIV = 4'd8;
  localparam logic [3:0] OPC_MOD = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick_start;
    logic prog_re;
    logic stk_re;
    logic stk_we;
    logic push_tok;
    logic push_not;
    logic alu_load;
    logic div_start;
    logic div_load;
    logic out_load;
    logic out_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] tok_kind;
    logic       tok_div;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/bre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bre_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/bre_div.sv
// Iterative signed divide and modulo, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module bre_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        want_mod_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output      logic        done_o,
  output      logic [31:0] result_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        sa_q, sa_d, sb_q, sb_d, mod_q, mod_d, zero_q, zero_d;
  logic [31:0] res_q, res_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    mod_d  = mod_q;
    zero_d = zero_q;
    res_d  = res_q;
    rem_sh  = {rem_q[31:0], quo_q[31]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      sa_d   = a_i[31];
      sb_d   = b_i[31];
      quo_d  = a_i[31] ? (32'd0 - a_i) : a_i;
      dvs_d  = b_i[31] ? (32'd0 - b_i) : b_i;
      zero_d = (b_i == 32'd0);
      mod_d  = want_mod_i;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (zero_q) begin
          res_d = '0;
        end else if (mod_q) begin
          res_d = sa_q ? (32'd0 - rem_d[31:0]) : rem_d[31:0];
        end else begin
          res_d = (sa_q ^ sb_q) ? (32'd0 - quo_d) : quo_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    mod_q  <= mod_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

>>> rtl/bre_dp.sv
// Datapath: program store, operand stack, top-of-stack register, ALU,
// divider, time counter and output register. Depends on bre_pkg, bre_ram, bre_div.
`default_nettype none
module bre_dp #(
  parameter int unsigned PROGRAM_DEPTH = 32,
  parameter int unsigned STACK_DEPTH   = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_accept_i,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [4:0]                       slot_index_i,
  input  wire logic [1:0]                       token_kind_i,
  input  wire logic [3:0]                       operator_code_i,
  input  wire logic [30:0]                      literal_value_i,
  input  wire logic [30:0]                      new_time_i,
  input  wire logic [30:0]                      sample_position_i,
  input  wire bre_pkg::cmd_t                    cmd_i,
  input  wire logic [$clog2(PROGRAM_DEPTH)-1:0] prog_raddr_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0]   stk_waddr_i,
  input  wire logic [$clog2(STACK_DEPTH)-1:0]   stk_raddr_i,
  output      bre_pkg::stat_t                   stat_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [31:0]                      result_value_o,
  output      logic                             status_o
);

  localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);

  logic [30:0] time_q, t_q, samp_q;
  logic [31:0] tos_q;
  logic        out_valid_q, status_q;
  logic [31:0] result_q;

  logic                         prog_we;
  logic [PAW-1:0]               prog_waddr;
  logic [bre_pkg::TOK_W-1:0]    prog_wdata, prog_rdata;
  logic [1:0]                   tk_kind;
  logic [3:0]                   tk_opc;
  logic [30:0]                  tk_lit;
  logic [31:0]                  nos, alu_res, prod, push_val, div_res;
  logic                         div_done;

  assign prog_we    = in_accept_i && (operation_i == bre_pkg::OP_WRITE)
                      && (int'(slot_index_i) < PROGRAM_DEPTH);
  assign prog_waddr = PAW'(slot_index_i);
  assign prog_wdata = {token_kind_i, operator_code_i, literal_value_i};

  bre_ram #(.WIDTH(bre_pkg::TOK_W), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .re_i    (cmd_i.prog_re),
    .raddr_i (prog_raddr_i),
    .rdata_o (prog_rdata)
  );

  assign {tk_kind, tk_opc, tk_lit} = prog_rdata;

  bre_ram #(.WIDTH(bre_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.stk_we),
    .waddr_i (stk_waddr_i),
    .wdata_i (tos_q),
    .re_i    (cmd_i.stk_re),
    .raddr_i (stk_raddr_i),
    .rdata_o (nos)
  );

  bre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .want_mod_i (tk_opc == bre_pkg::OPC_MOD),
    .a_i        (nos),
    .b_i        (tos_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  assign prod = nos * tos_q;

  always_comb begin
    case (tk_opc)
      bre_pkg::OPC_SHL: alu_res = nos << tos_q[4:0];
      bre_pkg::OPC_SHR: alu_res = $unsigned($signed(nos) >>> tos_q[4:0]);
      bre_pkg::OPC_XOR: alu_res = nos ^ tos_q;
      bre_pkg::OPC_OR:  alu_res = nos | tos_q;
      bre_pkg::OPC_AND: alu_res = nos & tos_q;
      bre_pkg::OPC_ADD: alu_res = nos + tos_q;
      bre_pkg::OPC_SUB: alu_res = nos - tos_q;
      bre_pkg::OPC_MUL: alu_res = prod;
      default:          alu_res = '0;
    endcase
  end

  always_comb begin
    if (cmd_i.push_not) begin
      push_val = (tk_kind == bre_pkg::KIND_LIT) ? ~{1'b0, tk_lit} : ~{1'b0, samp_q};
    end else if (tk_kind == bre_pkg::KIND_LIT) begin
      push_val = {1'b0, tk_lit};
    end else begin
      push_val = {1'b0, t_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= bre_pkg::TIME_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept_i && (operation_i == bre_pkg::OP_SET)) begin
        time_q <= new_time_i;
      end else if (cmd_i.tick_start) begin
        time_q <= time_q + 31'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      t_q    <= time_q;
      samp_q <= sample_position_i;
    end
    if (cmd_i.push_tok || cmd_i.push_not) begin
      tos_q <= push_val;
    end else if (cmd_i.alu_load) begin
      tos_q <= alu_res;
    end else if (cmd_i.div_load) begin
      tos_q <= div_res;
    end
    if (cmd_i.out_load) begin
      result_q <= cmd_i.out_err ? 32'd0 : tos_q;
      status_q <= cmd_i.out_err;
    end
  end

  assign stat_o.tok_kind = tk_kind;
  assign stat_o.tok_div  = (tk_opc == bre_pkg::OPC_DIV) || (tk_opc == bre_pkg::OPC_MOD);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

endmodule
`default_nettype wire

>>> rtl/bre_ctrl.sv
// Controller: walks the program token by token, tracks the program counter,
// stack depth and error flag. Depends on bre_pkg.
`default_nettype none
module bre_ctrl #(
  parameter int unsigned PROGRAM_DEPTH = 32,
  parameter int unsigned STACK_DEPTH   = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_accept_i,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [bre_pkg::LEN_W-1:0]        prog_len_i,
  input  wire bre_pkg::stat_t                   stat_i,
  output      bre_pkg::cmd_t                    cmd_o,
  output      logic [$clog2(PROGRAM_DEPTH)-1:0] prog_raddr_o,
  output      logic [$clog2(STACK_DEPTH)-1:0]   stk_waddr_o,
  output      logic [$clog2(STACK_DEPTH)-1:0]   stk_raddr_o,
  output      logic                             busy_o
);

  localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DEC    = 3'd2;
  localparam logic [2:0] S_NOT    = 3'd3;
  localparam logic [2:0] S_NOS    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [PCW-1:0] pc_q, pc_d, len, pc_inc;
  logic [SPW-1:0] sp_q, sp_d;
  logic           err_q, err_d;
  logic           full;

  assign len    = (int'(prog_len_i) > PROGRAM_DEPTH) ? PCW'(PROGRAM_DEPTH)
                                                     : PCW'(prog_len_i);
  assign pc_inc = pc_q + PCW'(1);
  assign full   = (int'(sp_q) >= STACK_DEPTH);

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    sp_d         = sp_q;
    err_d        = err_q;
    cmd_o        = '0;
    prog_raddr_o = PAW'(pc_q);
    stk_waddr_o  = SAW'(sp_q - SPW'(1));
    stk_raddr_o  = SAW'(sp_q - SPW'(2));
    unique case (state_q)
      S_IDLE: begin
        if (in_accept_i && (operation_i == bre_pkg::OP_TICK)) begin
          cmd_o.tick_start = 1'b1;
          pc_d    = '0;
          sp_d    = '0;
          err_d   = 1'b0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (pc_q >= len) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.prog_re = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.tok_kind)
          bre_pkg::KIND_OP: begin
            if (sp_q < SPW'(2)) begin
              err_d   = 1'b1;
              state_d = S_FINISH;
            end else begin
              cmd_o.stk_re = 1'b1;
              state_d      = S_NOS;
            end
          end
          bre_pkg::KIND_NOT: begin
            if (pc_inc >= len) begin
              err_d   = 1'b1;
              state_d = S_FINISH;
            end else begin
              cmd_o.prog_re = 1'b1;
              prog_raddr_o  = PAW'(pc_inc);
              pc_d          = pc_inc;
              state_d       = S_NOT;
            end
          end
          default: begin
            if (full) begin
              err_d   = 1'b1;
              state_d = S_FINISH;
            end else begin
              cmd_o.push_tok = 1'b1;
              cmd_o.stk_we   = (sp_q != '0);
              sp_d    = sp_q + SPW'(1);
              pc_d    = pc_inc;
              state_d = S_FETCH;
            end
          end
        endcase
      end
      S_NOT: begin
        if (full) begin
          err_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.push_not = 1'b1;
          cmd_o.stk_we   = (sp_q != '0);
          sp_d    = sp_q + SPW'(1);
          pc_d    = pc_inc;
          state_d = S_FETCH;
        end
      end
      S_NOS: begin
        if (stat_i.tok_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.alu_load = 1'b1;
          sp_d    = sp_q - SPW'(1);
          pc_d    = pc_inc;
          state_d = S_FETCH;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_load = 1'b1;
          sp_d    = sp_q - SPW'(1);
          pc_d    = pc_inc;
          state_d = S_FETCH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = err_q || (sp_q == '0);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      sp_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/bytebeat_rpn_evaluator.sv
// Top level of the bytebeat postfix evaluator: configuration register and the
// controller and datapath instances. Depends on bre_pkg, bre_ctrl, bre_dp.
//
//   channel  direction  handshake          transaction carries
//   in       input      in_valid/in_stall  operation, slot, token, time, sample
//   out      output     out_valid/out_stall result_value, status (ticks only)
//   cfg      input      cfg_valid/ready    program_length (6 bits)
//
// An accepted tick walks the program one token at a time: a literal or time
// token passes the fetch and decode states, a NOT with the token it consumes
// fetch, decode and NOT, a binary operator fetch, decode and operand read, and
// divide or modulo also the divide state, whose iterative divider produces one
// quotient bit per cycle. A final fetch ends the walk and the finish state loads
// the output register. The input is stalled while a tick is evaluated and while
// its result cannot yet enter the output register.
// Reset clears the time counter to its start value and the program length to
// zero; program slots hold nothing defined until written.
`default_nettype none
module bytebeat_rpn_evaluator #(
  parameter int unsigned PROGRAM_DEPTH = 32,
  parameter int unsigned STACK_DEPTH   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [4:0]  slot_index_i,
  input  wire logic [1:0]  token_kind_i,
  input  wire logic [3:0]  operator_code_i,
  input  wire logic [30:0] literal_value_i,
  input  wire logic [30:0] new_time_i,
  input  wire logic [30:0] sample_position_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic signed [31:0] result_value_o,
  output      logic        status_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [5:0]  cfg_data_i
);

  logic [bre_pkg::LEN_W-1:0]        prog_len_q;
  logic                             in_accept;
  logic                             busy;
  bre_pkg::cmd_t                    cmd;
  bre_pkg::stat_t                   stat;
  logic [$clog2(PROGRAM_DEPTH)-1:0] prog_raddr;
  logic [$clog2(STACK_DEPTH)-1:0]   stk_waddr, stk_raddr;
  logic [31:0]                      result;

  // Length register, always ready: users must write it only while idle; unchecked.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (cfg_valid_i) begin
      prog_len_q <= cfg_data_i;
    end
  end

  // New transactions are taken only while no tick is in flight.
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  bre_ctrl #(.PROGRAM_DEPTH(PROGRAM_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .operation_i  (operation_i),
    .prog_len_i   (prog_len_q),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .prog_raddr_o (prog_raddr),
    .stk_waddr_o  (stk_waddr),
    .stk_raddr_o  (stk_raddr),
    .busy_o       (busy)
  );

  bre_dp #(.PROGRAM_DEPTH(PROGRAM_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_accept_i       (in_accept),
    .operation_i       (operation_i),
    .slot_index_i      (slot_index_i),
    .token_kind_i      (token_kind_i),
    .operator_code_i   (operator_code_i),
    .literal_value_i   (literal_value_i),
    .new_time_i        (new_time_i),
    .sample_position_i (sample_position_i),
    .cmd_i             (cmd),
    .prog_raddr_i      (prog_raddr),
    .stk_waddr_i       (stk_waddr),
    .stk_raddr_i       (stk_raddr),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_value_o    (result),
    .status_o          (status_o)
  );

  assign result_value_o = $signed(result);

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the bytebeat postfix evaluator: a program loader
// and tick driver, a scoreboard class that predicts each tick result, and stall control.
// Depends on bre_pkg and bytebeat_rpn_evaluator only.
`default_nettype none

typedef struct {
  logic [1:0]  kind;
  logic [3:0]  opc;
  logic [30:0] lit;
} token_t;

typedef struct {
  logic [1:0]  operation;
  logic [4:0]  slot;
  token_t      tok;
  logic [30:0] new_time;
  logic [30:0] sample_pos;
} eval_cmd_t;

typedef struct {
  logic [31:0] value;
  logic        status;
} tick_result_t;

class tick_scoreboard;
  token_t       prog_store[32];
  logic [30:0]  time_count;
  logic [5:0]   prog_len;
  tick_result_t pending_ticks[$];
  bit           failed;

  function new();
    time_count = bre_pkg::TIME_RESET;
    prog_len   = '0;
    failed     = 0;
  endfunction

  function void set_length(logic [5:0] len);
    prog_len = len;
  endfunction

  function logic [31:0] alu(logic [3:0] opc, logic [31:0] a, logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (opc)
      bre_pkg::OPC_SHL: return a << sh;
      bre_pkg::OPC_SHR: return $signed(a) >>> sh;
      bre_pkg::OPC_XOR: return a ^ b;
      bre_pkg::OPC_OR:  return a | b;
      bre_pkg::OPC_AND: return a & b;
      bre_pkg::OPC_ADD: return a + b;
      bre_pkg::OPC_SUB: return a - b;
      bre_pkg::OPC_MUL: return a * b;
      bre_pkg::OPC_DIV, bre_pkg::OPC_MOD: begin
        if (b == 0) return 32'd0;
        // The most negative value over -1 wraps; its remainder is zero.
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
          return (opc == bre_pkg::OPC_DIV) ? a : 32'd0;
        if (opc == bre_pkg::OPC_DIV) return $signed(a) / $signed(b);
        return $signed(a) % $signed(b);
      end
      default: return 32'd0;
    endcase
  endfunction

  // Notes one accepted input transaction and predicts its result, if any.
  function void note_command(eval_cmd_t c);
    logic [31:0]  stack[16];
    logic [31:0]  v;
    logic [31:0]  t;
    int           sp;
    int           len;
    int           i;
    bit           err;
    tick_result_t r;
    case (c.operation)
      bre_pkg::OP_WRITE: prog_store[c.slot] = c.tok;
      bre_pkg::OP_SET:   time_count = c.new_time;
      bre_pkg::OP_TICK: begin
        t = {1'b0, time_count};
        time_count = time_count + 31'd1;
        len = (prog_len > 32) ? 32 : prog_len;
        sp = 0;
        err = 0;
        i = 0;
        while (i < len && !err) begin
          if (prog_store[i].kind == bre_pkg::KIND_OP) begin
            if (sp < 2) err = 1;
            else begin
              v = alu(prog_store[i].opc, stack[sp-2], stack[sp-1]);
              sp = sp - 2;
              stack[sp] = v;
              sp++;
            end
          end else begin
            if (prog_store[i].kind == bre_pkg::KIND_LIT) v = {1'b0, prog_store[i].lit};
            else if (prog_store[i].kind == bre_pkg::KIND_TIME) v = t;
            else if (i + 1 >= len) err = 1;
            else begin
              // A NOT swallows the following token as its operand.
              i++;
              if (prog_store[i].kind == bre_pkg::KIND_LIT) v = ~{1'b0, prog_store[i].lit};
              else v = ~{1'b0, c.sample_pos};
            end
            if (!err) begin
              if (sp >= 16) err = 1;
              else begin
                stack[sp] = v;
                sp++;
              end
            end
          end
          i++;
        end
        if (sp == 0) err = 1;
        r.value  = err ? 32'd0 : stack[sp-1];
        r.status = err;
        pending_ticks.insert(pending_ticks.size(), r);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [31:0] value, logic status);
    tick_result_t e;
    if (pending_ticks.size() == 0) begin
      $error("unexpected result: result_value %h status %0d", value, status);
      failed = 1;
      return;
    end
    e = pending_ticks.pop_front();
    if (value !== e.value) begin
      $error("result_value: expected %h, actual %h", e.value, value);
      failed = 1;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, status);
      failed = 1;
    end
  endfunction
endclass

module testbench;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [4:0]  slot_index;
  logic [1:0]  token_kind;
  logic [3:0]  operator_code;
  logic [30:0] literal_value;
  logic [30:0] new_time;
  logic [30:0] sample_position;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] result_value;
  logic        status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;

  tick_scoreboard sb;
  bit             hold_off_done;
  token_t         prog_q[$];

  bytebeat_rpn_evaluator dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .slot_index_i      (slot_index),
    .token_kind_i      (token_kind),
    .operator_code_i   (operator_code),
    .literal_value_i   (literal_value),
    .new_time_i        (new_time),
    .sample_position_i (sample_position),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .result_value_o    (result_value),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous upper bound: even a run of nothing but full-length divide
  // programs under heavy output stalls finishes far below this.
  initial begin
    #60000000;
    $display("simulation failed");
    $finish;
  end

  // Every transaction that leaves the block is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(result_value, status);
  end

  // Receiver stall pattern: mostly short gaps, a few long ones, free-running
  // stretches, and once a very long hold-off so the block backs up its input.
  initial begin
    int run;
    int cycles;
    out_stall = 1'b0;
    cycles = 0;
    hold_off_done = 0;
    @(posedge rst_n);
    forever begin
      if (!hold_off_done && cycles > 3000) begin
        hold_off_done = 1;
        run = 600;
        @(negedge clk) out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) < 6) begin
        run = $urandom_range(1, 40);
        @(negedge clk) out_stall <= 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        @(negedge clk) out_stall <= 1'b1;
      end
      repeat (run - 1) @(negedge clk);
      cycles += run;
    end
  end

  function automatic logic [30:0] pick_literal();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return 31'd1;
      2: return 31'h7FFF_FFFF;
      3: return 31'($urandom_range(0, 40));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic eval_cmd_t random_command();
    eval_cmd_t c;
    c.operation      = 2'($urandom);
    c.slot           = 5'($urandom);
    c.tok.kind       = 2'($urandom);
    c.tok.opc        = 4'($urandom);
    c.tok.lit        = pick_literal();
    c.new_time       = ($urandom_range(0, 3) == 0) ? 31'h7FFF_FFF0 + 31'($urandom_range(0, 15))
                                                    : 31'($urandom);
    c.sample_pos     = pick_literal();
    return c;
  endfunction

  // Offers one transaction and waits until the block takes it. Valid stays
  // high afterwards; the next call or idle_input decides whether it drops.
  task automatic send(eval_cmd_t c, int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    operation       = c.operation;
    slot_index      = c.slot;
    token_kind      = c.tok.kind;
    operator_code   = c.tok.opc;
    literal_value   = c.tok.lit;
    new_time        = c.new_time;
    sample_position = c.sample_pos;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
  endtask

  function automatic int pick_gap(bit busy);
    if (busy) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
  endfunction

  task automatic write_token(int slot, token_t tok, bit busy);
    eval_cmd_t c;
    c = random_command();
    c.operation = bre_pkg::OP_WRITE;
    c.slot      = 5'(slot);
    c.tok       = tok;
    send(c, pick_gap(busy));
  endtask

  task automatic tick(logic [30:0] spos);
    eval_cmd_t c;
    c = random_command();
    c.operation  = bre_pkg::OP_TICK;
    c.sample_pos = spos;
    send(c, pick_gap(0));
  endtask

  // Lets every result drain, then waits out any tick still in flight.
  task automatic idle_input();
    @(negedge clk) in_valid = 1'b0;
    while (sb.pending_ticks.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_length(logic [5:0] len);
    idle_input();
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(len);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  function automatic token_t make_token(logic [1:0] kind, logic [3:0] opc, logic [30:0] lit);
    token_t t;
    t.kind = kind;
    t.opc  = opc;
    t.lit  = lit;
    return t;
  endfunction

  // Builds a program of the given length that mostly keeps the stack legal,
  // so evaluation reaches deep into the token list.
  task automatic build_program(int len);
    int depth;
    int i;
    prog_q.delete();
    depth = 0;
    i = 0;
    while (i < len) begin
      if (depth >= 2 && (depth >= 15 || $urandom_range(0, 1) == 0)) begin
        prog_q.insert(prog_q.size(), make_token(bre_pkg::KIND_OP,
          ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)),
          31'($urandom)));
        depth--;
        i++;
      end else if (len - i >= 2 && $urandom_range(0, 3) == 0) begin
        prog_q.insert(prog_q.size(),
                      make_token(bre_pkg::KIND_NOT, 4'($urandom), 31'($urandom)));
        prog_q.insert(prog_q.size(),
                      make_token(2'($urandom), 4'($urandom), pick_literal()));
        depth++;
        i += 2;
      end else begin
        prog_q.insert(prog_q.size(),
                      make_token(($urandom_range(0, 2) == 0) ? bre_pkg::KIND_TIME
                                                             : bre_pkg::KIND_LIT,
                                 4'($urandom), pick_literal()));
        depth++;
        i++;
      end
    end
    // Now and then one token is spoiled so that error paths show up too.
    if (len > 0 && $urandom_range(0, 6) == 0)
      prog_q[$urandom_range(0, len - 1)] = make_token(2'($urandom), 4'($urandom), pick_literal());
  endtask

  initial begin
    eval_cmd_t   c;
    logic [5:0]  len;
    int          eff;
    bit          busy;
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = bre_pkg::OP_WRITE;
    slot_index = '0;
    token_kind = bre_pkg::KIND_LIT;
    operator_code = bre_pkg::OPC_SHL;
    literal_value = '0;
    new_time = '0;
    sample_position = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // An empty program flags an error before any slot holds a token.
    tick(31'h7FFF_FFFF);

    // Fill every slot so that no later tick reads an unwritten one.
    for (int s = 0; s < 32; s++)
      write_token(s, make_token(bre_pkg::KIND_LIT, bre_pkg::OPC_ADD, 31'(s)), 1);

    // Each operator, including the unused codes, on the most negative value
    // and -1, both made with NOT of a literal.
    write_token(0, make_token(bre_pkg::KIND_NOT, bre_pkg::OPC_SHL, 31'd0), 1);
    write_token(1, make_token(bre_pkg::KIND_LIT, bre_pkg::OPC_SHL, 31'h7FFF_FFFF), 1);
    write_token(2, make_token(bre_pkg::KIND_NOT, bre_pkg::OPC_SHL, 31'd0), 1);
    write_token(3, make_token(bre_pkg::KIND_LIT, bre_pkg::OPC_SHL, 31'd0), 1);
    set_length(6'd5);
    for (int op = 0; op < 16; op++) begin
      write_token(4, make_token(bre_pkg::KIND_OP, 4'(op), 31'd0), 0);
      tick(31'd0);
    end

    // Division by zero, NOT of a time token, NOT as the last token, underflow,
    // overflow, leftover values and saturation of the program length.
    write_token(0, make_token(bre_pkg::KIND_TIME, bre_pkg::OPC_SHL, 31'd0), 1);
    write_token(1, make_token(bre_pkg::KIND_LIT, bre_pkg::OPC_SHL, 31'd0), 1);
    write_token(2, make_token(bre_pkg::KIND_OP, bre_pkg::OPC_DIV, 31'd0), 1);
    write_token(3, make_token(bre_pkg::KIND_NOT, bre_pkg::OPC_SHL, 31'd0), 1);
    write_token(4, make_token(bre_pkg::KIND_TIME, bre_pkg::OPC_SHL, 31'd0), 1);
    c = random_command();
    c.operation = bre_pkg::OP_SET;
    c.new_time  = 31'h7FFF_FFFF;
    send(c, 0);
    set_length(6'd3);
    tick(31'd5);
    tick(31'd5);
    set_length(6'd4);
    tick(31'd9);
    set_length(6'd5);
    tick(31'h7FFF_FFFF);
    set_length(6'd1);
    write_token(0, make_token(bre_pkg::KIND_OP, bre_pkg::OPC_MOD, 31'd0), 1);
    tick(31'd0);
    for (int s = 0; s < 32; s++)
      write_token(s, make_token(bre_pkg::KIND_LIT, bre_pkg::OPC_SHL, 31'(s + 1)), 1);
    set_length(6'd63);
    tick(31'd0);
    set_length(6'd16);
    tick(31'd0);
    c = random_command();
    c.operation = OP_SPARE;
    send(c, 0);

    // Random phases: a fresh, mostly legal program per length setting, then a mix of
    // ticks, stray token writes, time loads and unused operations.
    for (int ph = 0; ph < 18; ph++) begin
      case (ph % 6)
        0: len = 6'd0;
        1: len = 6'd32;
        2: len = 6'($urandom_range(33, 63));
        3: len = 6'd1;
        default: len = 6'($urandom_range(2, 31));
      endcase
      set_length(len);
      eff = (len > 32) ? 32 : len;
      busy = ($urandom_range(0, 3) == 0);
      build_program(eff);
      foreach (prog_q[k]) write_token(k, prog_q[k], busy);
      for (int n = 0; n < 18; n++) begin
        c = random_command();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: c.operation = bre_pkg::OP_TICK;
          10, 11: c.operation = bre_pkg::OP_WRITE;
          12, 13: c.operation = bre_pkg::OP_SET;
          14: c.operation = OP_SPARE;
          default: begin
            // Rewrite a slot with a legal token of the same role.
            c.operation = bre_pkg::OP_WRITE;
            if (eff > 0) begin
              c.slot = 5'($urandom_range(0, eff - 1));
              c.tok  = prog_q[c.slot];
              c.tok.lit = pick_literal();
            end
          end
        endcase
        send(c, pick_gap(busy));
      end
    end

    idle_input();
    if (!sb.failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
rtl/bre_pkg.sv
rtl/bre_ram.sv
rtl/bre_div.sv
rtl/bre_dp.sv
rtl/bre_ctrl.sv
rtl/bytebeat_rpn_evaluator.sv
verif/testbench.sv
